// ----- rtl/ste_pkg.sv -----
// Package for the sinusoidal timestep embedding unit: sizes, fixed-point
// constants, the per-term reciprocal tables and the frequency ROM builder.
// Depends on nothing.
package ste_pkg;

  localparam int unsigned EMBED_DIM = 256;
  localparam int unsigned NUM_FREQS = (EMBED_DIM / 2 < 1) ? 1 : EMBED_DIM / 2;

  localparam int unsigned TS_W  = 27;
  localparam int unsigned IDX_W = 7;
  localparam int unsigned OUT_W = 16;

  localparam int unsigned ROM_DEPTH = (NUM_FREQS < (1 << IDX_W)) ? NUM_FREQS : (1 << IDX_W);
  localparam int unsigned ROM_AW    = (ROM_DEPTH > 1) ? $clog2(ROM_DEPTH) : 1;

  // Frequency word: f_i / (2*pi) in Q36
  localparam int unsigned W_W    = 34;
  localparam int unsigned W_LO_W = 17;
  localparam int unsigned W_HI_W = W_W - W_LO_W;

  localparam logic [63:0] LOG2_1E4_Q32 = 64'd57070290109;
  localparam logic [63:0] LN2_Q32      = 64'd2977044472;
  localparam logic [63:0] INV2PI_Q32   = 64'd683565276;
  localparam logic [63:0] PIHALF_Q30   = 64'd1686629713;
  localparam logic [63:0] ONE_Q31      = 64'd2147483648;
  localparam logic [30:0] ONE_Q30      = 31'd1073741824;

  localparam int unsigned N_TERMS = 6;

  // floor(v / d) for v < 2^30 as (v * ceil(2^(30+l) / d)) >> (30+l), l = ceil(log2 d)
  localparam int unsigned SIN_SH [N_TERMS] = '{33, 35, 36, 37, 37, 38};
  localparam int unsigned COS_SH [N_TERMS] = '{31, 34, 35, 36, 37, 38};

  localparam logic [63:0] SIN_RCP [N_TERMS] = '{
    ((64'd1 << 33) + 64'd5)   / 64'd6,
    ((64'd1 << 35) + 64'd19)  / 64'd20,
    ((64'd1 << 36) + 64'd41)  / 64'd42,
    ((64'd1 << 37) + 64'd71)  / 64'd72,
    ((64'd1 << 37) + 64'd109) / 64'd110,
    ((64'd1 << 38) + 64'd155) / 64'd156
  };

  localparam logic [63:0] COS_RCP [N_TERMS] = '{
    ((64'd1 << 31) + 64'd1)   / 64'd2,
    ((64'd1 << 34) + 64'd11)  / 64'd12,
    ((64'd1 << 35) + 64'd29)  / 64'd30,
    ((64'd1 << 36) + 64'd55)  / 64'd56,
    ((64'd1 << 37) + 64'd89)  / 64'd90,
    ((64'd1 << 38) + 64'd131) / 64'd132
  };

  // Quadrant codes of the phase
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef logic [W_W-1:0] freq_rom_t [ROM_DEPTH];

  // f_i / (2*pi) in Q36, with f_i = 2^-(i * log2(10000) / half)
  function automatic logic [W_W-1:0] freq_word(input int unsigned idx);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] y;
    logic [63:0] sum;
    logic [63:0] term;
    int unsigned n;
    x    = (64'(idx) * LOG2_1E4_Q32) / 64'(NUM_FREQS);
    n    = 32'(x >> 32);
    r    = x & 64'hFFFF_FFFF;
    y    = (r * LN2_Q32) >> 33;
    sum  = ONE_Q31;
    term = ONE_Q31;
    term = ((term * y) >> 31) / 64'd1;  sum = sum - term;
    term = ((term * y) >> 31) / 64'd2;  sum = sum + term;
    term = ((term * y) >> 31) / 64'd3;  sum = sum - term;
    term = ((term * y) >> 31) / 64'd4;  sum = sum + term;
    term = ((term * y) >> 31) / 64'd5;  sum = sum - term;
    term = ((term * y) >> 31) / 64'd6;  sum = sum + term;
    term = ((term * y) >> 31) / 64'd7;  sum = sum - term;
    term = ((term * y) >> 31) / 64'd8;  sum = sum + term;
    term = ((term * y) >> 31) / 64'd9;  sum = sum - term;
    term = ((term * y) >> 31) / 64'd10; sum = sum + term;
    term = ((term * y) >> 31) / 64'd11; sum = sum - term;
    term = ((term * y) >> 31) / 64'd12; sum = sum + term;
    term = ((term * y) >> 31) / 64'd13; sum = sum - term;
    term = ((term * y) >> 31) / 64'd14; sum = sum + term;
    return W_W'((sum * INV2PI_Q32) >> (27 + n));
  endfunction

  function automatic freq_rom_t build_freq_rom();
    freq_rom_t rom;
    for (int unsigned i = 0; i < ROM_DEPTH; i++) begin
      rom[i] = freq_word(i);
    end
    return rom;
  endfunction

endpackage

// ----- rtl/sinusoidal_timestep_embedding_unit.sv -----
// Top level of the sinusoidal timestep embedding unit: frequency ROM, phase
// multiply, quadrant fold and a pipelined Taylor evaluation of sin and cos.
// Depends on ste_pkg.
//
// Usage
//   Command channel: raise start_i with timestep_i (Q16) and freq_index_i.
//   The item transfers at the rising edge where start_i is high and busy_o
//   is low. busy_o stays low, so one item transfers every cycle.
//   Result channel: done_o is high for exactly one cycle with cos_value_o
//   and sin_value_o (signed Q14). The receiver cannot stall the result;
//   it must take it in that cycle.
//   Order: results transfer in the order of their items.
//   Throughput: one item per cycle; every stage is a register stage fed
//   each cycle, and the frequency ROM has one synchronous read port.
//   Pipeline: ROM read, two 27x17 partial products, phase add, quadrant
//   fold, angle multiply, angle squared, six multiply/reciprocal pairs for
//   the Taylor terms, final accumulate, rotate and round.
//   Reset: rst_ni clears all valid flags at once; items in flight are
//   dropped and no result appears until a new transfer. No clearing pass.
//   An index at or above EMBED_DIM/2 is saturated to the last frequency.
module sinusoidal_timestep_embedding_unit
  import ste_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [TS_W-1:0]         timestep_i,
  input  logic [IDX_W-1:0]        freq_index_i,
  output logic                    done_o,
  output logic signed [OUT_W-1:0] cos_value_o,
  output logic signed [OUT_W-1:0] sin_value_o
);

  typedef struct packed {
    logic [30:0] s_term;
    logic [30:0] c_term;
    logic [31:0] s_sum;
    logic [31:0] c_sum;
    logic [29:0] t2;
    logic [1:0]  quad;
    logic        swap;
  } trig_t;

  localparam freq_rom_t FREQ_ROM = build_freq_rom();

  // Round a Q30 magnitude to Q14 and apply the sign
  function automatic logic [OUT_W-1:0] to_q14(input logic [31:0] m, input logic neg);
    logic [31:0] rnd;
    logic [OUT_W-1:0] v;
    rnd = m + 32'd32768;
    v   = rnd[31:16];
    return neg ? (OUT_W'(0) - v) : v;
  endfunction

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Saturate the index to the last frequency
  logic [ROM_AW-1:0] idx_sat;
  always_comb begin
    if (32'(freq_index_i) >= NUM_FREQS) begin
      idx_sat = ROM_AW'(NUM_FREQS - 1);
    end else begin
      idx_sat = ROM_AW'(freq_index_i);
    end
  end

  // Valid flags, one per stage
  logic v_rom_q, v_mul_q, v_ph_q, v_fold_q, v_th_q, v_t2_q, v_fin_q, done_q;
  logic [N_TERMS:1] va_q, vb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_rom_q  <= 1'b0;
      v_mul_q  <= 1'b0;
      v_ph_q   <= 1'b0;
      v_fold_q <= 1'b0;
      v_th_q   <= 1'b0;
      v_t2_q   <= 1'b0;
      va_q     <= '0;
      vb_q     <= '0;
      v_fin_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      v_rom_q  <= accept;
      v_mul_q  <= v_rom_q;
      v_ph_q   <= v_mul_q;
      v_fold_q <= v_ph_q;
      v_th_q   <= v_fold_q;
      v_t2_q   <= v_th_q;
      va_q     <= {vb_q[N_TERMS-1:1], v_t2_q};
      vb_q     <= va_q;
      v_fin_q  <= vb_q[N_TERMS];
      done_q   <= v_fin_q;
    end
  end

  // Stage 1: frequency ROM read, hold the timestep
  logic [W_W-1:0]  w_q;
  logic [TS_W-1:0] ts_q;
  always_ff @(posedge clk_i) begin
    w_q  <= FREQ_ROM[idx_sat];
    ts_q <= timestep_i;
  end

  // Stage 2: two partial products of timestep times frequency word
  logic [TS_W+W_LO_W-1:0] prod_lo_q;
  logic [TS_W+W_HI_W-1:0] prod_hi_q;
  always_ff @(posedge clk_i) begin
    prod_lo_q <= (TS_W+W_LO_W)'(ts_q) * (TS_W+W_LO_W)'(w_q[W_LO_W-1:0]);
    prod_hi_q <= (TS_W+W_HI_W)'(ts_q) * (TS_W+W_HI_W)'(w_q[W_W-1:W_LO_W]);
  end

  // Stage 3: phase in turns, Q32, rounded and wrapped to one turn
  logic [51:0] ph_sum;
  logic [31:0] phase_q;
  assign ph_sum = 52'(prod_lo_q) + (52'(prod_hi_q) << W_LO_W) + (52'd1 << 19);
  always_ff @(posedge clk_i) begin
    phase_q <= ph_sum[51:20];
  end

  // Stage 4: fold the quarter turn to at most an eighth turn
  logic [29:0] a_fold_q;
  logic [1:0]  quad_fold_q;
  logic        swap_fold_q;
  logic        fold;
  assign fold = phase_q[29:0] > (30'd1 << 29);
  always_ff @(posedge clk_i) begin
    a_fold_q    <= fold ? (30'(ONE_Q30) - phase_q[29:0]) : phase_q[29:0];
    quad_fold_q <= phase_q[31:30];
    swap_fold_q <= fold;
  end

  // Stage 5: angle in radians, Q30
  logic [60:0] th_prod;
  logic [29:0] th_q;
  logic [1:0]  quad_th_q;
  logic        swap_th_q;
  assign th_prod = 61'(a_fold_q) * 61'(PIHALF_Q30);
  always_ff @(posedge clk_i) begin
    th_q      <= th_prod[59:30];
    quad_th_q <= quad_fold_q;
    swap_th_q <= swap_fold_q;
  end

  // Stage 6: angle squared, seed the series
  logic [59:0] t2_prod;
  trig_t       b_q [0:N_TERMS];
  trig_t       a_q [1:N_TERMS];
  assign t2_prod = 60'(th_q) * 60'(th_q);
  always_ff @(posedge clk_i) begin
    b_q[0].s_term <= 31'(th_q);
    b_q[0].c_term <= ONE_Q30;
    b_q[0].s_sum  <= 32'(th_q);
    b_q[0].c_sum  <= 32'(ONE_Q30);
    b_q[0].t2     <= t2_prod[59:30];
    b_q[0].quad   <= quad_th_q;
    b_q[0].swap   <= swap_th_q;
  end

  // Taylor terms: multiply by the squared angle, then divide by the
  // term's constant through its reciprocal. The previous term joins the
  // sums in the multiply stage of the next one.
  for (genvar k = 1; k <= N_TERMS; k++) begin : g_term
    localparam logic [31:0] RCP_S = 32'(SIN_RCP[k-1]);
    localparam logic [31:0] RCP_C = 32'(COS_RCP[k-1]);
    localparam int unsigned SH_S  = SIN_SH[k-1];
    localparam int unsigned SH_C  = COS_SH[k-1];
    localparam bit PREV_SUB       = ((k - 1) % 2) == 1;

    trig_t       a_d;
    trig_t       b_d;
    logic [61:0] ps;
    logic [61:0] pc;
    logic [63:0] qs;
    logic [63:0] qc;

    always_comb begin
      ps  = 62'(b_q[k-1].s_term) * 62'(b_q[k-1].t2);
      pc  = 62'(b_q[k-1].c_term) * 62'(b_q[k-1].t2);
      a_d = b_q[k-1];
      a_d.s_term = 31'(ps >> 30);
      a_d.c_term = 31'(pc >> 30);
      if (k > 1) begin
        if (PREV_SUB) begin
          a_d.s_sum = b_q[k-1].s_sum - 32'(b_q[k-1].s_term);
          a_d.c_sum = b_q[k-1].c_sum - 32'(b_q[k-1].c_term);
        end else begin
          a_d.s_sum = b_q[k-1].s_sum + 32'(b_q[k-1].s_term);
          a_d.c_sum = b_q[k-1].c_sum + 32'(b_q[k-1].c_term);
        end
      end
    end

    always_comb begin
      qs  = 64'(a_q[k].s_term) * 64'(RCP_S);
      qc  = 64'(a_q[k].c_term) * 64'(RCP_C);
      b_d = a_q[k];
      b_d.s_term = 31'(qs >> SH_S);
      b_d.c_term = 31'(qc >> SH_C);
    end

    always_ff @(posedge clk_i) begin
      a_q[k] <= a_d;
      b_q[k] <= b_d;
    end
  end

  // Final accumulate: the last term carries a plus sign
  logic [31:0] s_fin_q, c_fin_q;
  logic [1:0]  quad_fin_q;
  logic        swap_fin_q;
  always_ff @(posedge clk_i) begin
    s_fin_q    <= b_q[N_TERMS].s_sum + 32'(b_q[N_TERMS].s_term);
    c_fin_q    <= b_q[N_TERMS].c_sum + 32'(b_q[N_TERMS].c_term);
    quad_fin_q <= b_q[N_TERMS].quad;
    swap_fin_q <= b_q[N_TERMS].swap;
  end

  // Undo the fold, rotate by quadrant, round to Q14
  logic [31:0] s_base, c_base;
  logic [31:0] cm, sm;
  logic        cneg, sneg;
  always_comb begin
    s_base = swap_fin_q ? c_fin_q : s_fin_q;
    c_base = swap_fin_q ? s_fin_q : c_fin_q;
    case (quad_fin_q)
      QUAD_0: begin
        cm = c_base; cneg = 1'b0; sm = s_base; sneg = 1'b0;
      end
      QUAD_1: begin
        cm = s_base; cneg = 1'b1; sm = c_base; sneg = 1'b0;
      end
      QUAD_2: begin
        cm = c_base; cneg = 1'b1; sm = s_base; sneg = 1'b1;
      end
      QUAD_3: begin
        cm = s_base; cneg = 1'b0; sm = c_base; sneg = 1'b1;
      end
      default: begin
        cm = c_base; cneg = 1'b0; sm = s_base; sneg = 1'b0;
      end
    endcase
  end

  logic [OUT_W-1:0] cos_q, sin_q;
  always_ff @(posedge clk_i) begin
    cos_q <= to_q14(cm, cneg);
    sin_q <= to_q14(sm, sneg);
  end

  assign done_o      = done_q;
  assign cos_value_o = signed'(cos_q);
  assign sin_value_o = signed'(sin_q);

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for sinusoidal_timestep_embedding_unit: drives
// timestep/index transfers, predicts each cos/sin pair in fixed point and
// compares every result in order. Depends on ste_pkg and the RTL top level.
module tb
  import ste_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Fixed-point constants of the datapath
  localparam logic [63:0] LOG2_TEN_K_Q32 = 64'd57070290109;
  localparam logic [63:0] LN_TWO_Q32     = 64'd2977044472;
  localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;
  localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
  localparam logic [63:0] UNIT_Q31       = 64'd2147483648;
  localparam logic [63:0] UNIT_Q30       = 64'd1073741824;
  localparam int unsigned TS_UNIT        = 65536;   // 1.0 in Q16
  localparam int unsigned TS_RANGE_TOP   = 1024 * TS_UNIT;

  typedef struct packed {
    logic signed [OUT_W-1:0] cos_q14;
    logic signed [OUT_W-1:0] sin_q14;
  } embed_pair_t;

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    start_i      = 1'b0;
  logic [TS_W-1:0]         timestep_i   = '0;
  logic [IDX_W-1:0]        freq_index_i = '0;
  logic                    busy_o;
  logic                    done_o;
  logic signed [OUT_W-1:0] cos_value_o;
  logic signed [OUT_W-1:0] sin_value_o;

  embed_pair_t pending_pairs[$];
  int          mismatch_count  = 0;
  int          sender_idle_pct = 0;

  sinusoidal_timestep_embedding_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .timestep_i  (timestep_i),
    .freq_index_i(freq_index_i),
    .done_o      (done_o),
    .cos_value_o (cos_value_o),
    .sin_value_o (sin_value_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Taylor series of sin and cos for an angle in radians Q30, 7 terms each
  function automatic void taylor_sincos(input logic [63:0] angle,
                                        output logic [63:0] sin_q30,
                                        output logic [63:0] cos_q30);
    logic [63:0] angle_sq;
    logic [63:0] sin_term;
    logic [63:0] cos_term;
    int          k;
    angle_sq = (angle * angle) >> 30;
    sin_q30  = angle;
    sin_term = angle;
    cos_q30  = UNIT_Q30;
    cos_term = UNIT_Q30;
    for (k = 1; k <= 6; k++) begin
      sin_term = ((sin_term * angle_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
      cos_term = ((cos_term * angle_sq) >> 30) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        sin_q30 = sin_q30 - sin_term;
        cos_q30 = cos_q30 - cos_term;
      end else begin
        sin_q30 = sin_q30 + sin_term;
        cos_q30 = cos_q30 + cos_term;
      end
    end
  endfunction

  // Round a Q30 magnitude to Q14 and apply the sign
  function automatic logic signed [OUT_W-1:0] round_to_q14(input logic [63:0] mag,
                                                           input bit negate);
    logic [63:0] rounded;
    rounded = (mag + 64'd32768) >> 16;
    return negate ? OUT_W'(64'd0 - rounded) : OUT_W'(rounded);
  endfunction

  // Embedding entries i and i+half for one timestep
  function automatic embed_pair_t predict_embedding(input logic [TS_W-1:0]  ts,
                                                    input logic [IDX_W-1:0] idx);
    logic [63:0] index_sat;
    logic [63:0] log_pos;
    logic [63:0] log_frac;
    logic [63:0] exp_arg;
    logic [63:0] exp_term;
    logic [63:0] neg_pow;
    logic [63:0] turns_rate;
    logic [63:0] phase;
    logic [63:0] quarter_frac;
    logic [63:0] angle;
    logic [63:0] sin_mag;
    logic [63:0] cos_mag;
    logic [63:0] cos_out;
    logic [63:0] sin_out;
    logic [1:0]  quadrant;
    int unsigned octave;
    int          k;
    bit          cos_neg;
    bit          sin_neg;
    embed_pair_t pair;

    index_sat = 64'(idx);
    if (index_sat >= 64'(NUM_FREQS)) index_sat = 64'(NUM_FREQS) - 64'd1;

    // Split i*log2(10000)/half into integer octaves and a Q32 fraction
    log_pos  = (index_sat * LOG2_TEN_K_Q32) / 64'(NUM_FREQS);
    octave   = 32'(log_pos >> 32);
    log_frac = log_pos & 64'hFFFF_FFFF;

    // 2^-frac = exp(-frac*ln2) in Q31
    exp_arg  = (log_frac * LN_TWO_Q32) >> 33;
    neg_pow  = UNIT_Q31;
    exp_term = UNIT_Q31;
    for (k = 1; k <= 14; k++) begin
      exp_term = ((exp_term * exp_arg) >> 31) / 64'(k);
      if (k % 2 == 1) neg_pow = neg_pow - exp_term;
      else            neg_pow = neg_pow + exp_term;
    end

    // Frequency in turns per unit time (Q36), then phase in turns (Q32)
    turns_rate = (neg_pow * INV_TWO_PI_Q32) >> (27 + octave);
    phase      = ((64'(ts) * turns_rate + (64'd1 << 19)) >> 20) & 64'hFFFF_FFFF;

    quadrant     = phase[31:30];
    quarter_frac = phase & (UNIT_Q30 - 64'd1);
    if (quarter_frac > (UNIT_Q30 >> 1)) begin
      // Fold the upper half of the quarter and swap sin with cos
      angle = ((UNIT_Q30 - quarter_frac) * HALF_PI_Q30) >> 30;
      taylor_sincos(angle, cos_mag, sin_mag);
    end else begin
      angle = (quarter_frac * HALF_PI_Q30) >> 30;
      taylor_sincos(angle, sin_mag, cos_mag);
    end

    case (quadrant)
      QUAD_0: begin cos_out = cos_mag; cos_neg = 1'b0; sin_out = sin_mag; sin_neg = 1'b0; end
      QUAD_1: begin cos_out = sin_mag; cos_neg = 1'b1; sin_out = cos_mag; sin_neg = 1'b0; end
      QUAD_2: begin cos_out = cos_mag; cos_neg = 1'b1; sin_out = sin_mag; sin_neg = 1'b1; end
      default: begin cos_out = sin_mag; cos_neg = 1'b0; sin_out = cos_mag; sin_neg = 1'b1; end
    endcase

    pair.cos_q14 = round_to_q14(cos_out, cos_neg);
    pair.sin_q14 = round_to_q14(sin_out, sin_neg);
    return pair;
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: predict on every command transfer, check every result strobe.
  // Inputs change only by nonblocking assignment, so both are sampled here
  // with their pre-edge values.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) begin
      pending_pairs.push_back(predict_embedding(timestep_i, freq_index_i));
    end
    if (rst_ni && done_o !== 1'b0) begin
      if (pending_pairs.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result cos=%0d sin=%0d", $time, cos_value_o, sin_value_o);
      end else begin
        embed_pair_t want;
        want = pending_pairs.pop_front();
        if (cos_value_o !== want.cos_q14) begin
          mismatch_count++;
          $display("%0t: cos_value mismatch: expected %0d, actual %0d",
                   $time, want.cos_q14, cos_value_o);
        end
        if (sin_value_o !== want.sin_q14) begin
          mismatch_count++;
          $display("%0t: sin_value mismatch: expected %0d, actual %0d",
                   $time, want.sin_q14, sin_value_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------

  // Hold start_i and the fields until the transfer edge. start_i stays high
  // after the transfer, so back-to-back items need no gap; an idle cycle
  // drops it before the next item.
  task automatic send_item(input logic [TS_W-1:0] ts, input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i      <= 1'b1;
    timestep_i   <= ts;
    freq_index_i <= idx;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // All-zero, all-one and alternating patterns of both fields, plus the range top and one
  task automatic test_field_extremes();
    send_item('0, '0);
    send_item('0, '1);
    send_item('1, '0);
    send_item('1, '1);
    send_item(TS_W'(TS_RANGE_TOP), '0);
    send_item(TS_W'(TS_RANGE_TOP), '1);
    send_item(TS_W'(1), '0);
    send_item(TS_W'(1), '1);
    send_item(TS_W'(27'h555_5555), IDX_W'(7'h55));
    send_item(TS_W'(27'h2AA_AAAA), IDX_W'(7'h2A));
  endtask

  // Unit frequency: land near each quadrant edge and the eighth-turn fold
  task automatic test_zero_index();
    send_item(TS_W'(51472), '0);   // pi/4
    send_item(TS_W'(102944), '0);  // pi/2
    send_item(TS_W'(205887), '0);  // pi
    send_item(TS_W'(308831), '0);  // 3*pi/2
    send_item(TS_W'(411775), '0);  // 2*pi
  endtask

  // Last valid index, which the all-one index field also selects
  task automatic test_index_saturation();
    send_item(TS_W'(500 * TS_UNIT), IDX_W'(NUM_FREQS - 1));
    send_item(TS_W'(500 * TS_UNIT), '1);
    send_item(TS_W'(777 * TS_UNIT + 12345), IDX_W'(NUM_FREQS - 1));
  endtask

  // Timesteps beyond the nominal range wrap the phase
  task automatic test_wrapped_timestep();
    send_item(TS_W'(1025 * TS_UNIT), '0);
    send_item(TS_W'($urandom_range(2 ** TS_W - 1, TS_RANGE_TOP + 1)), IDX_W'($urandom));
    send_item(TS_W'($urandom_range(2 ** TS_W - 1, TS_RANGE_TOP + 1)), IDX_W'($urandom));
  endtask

  // Mostly index sweeps at one timestep, as an embedding vector is built,
  // mixed with stray items over the full field ranges
  task automatic test_random_traffic(input int idle_pct, input int item_goal);
    int               sent;
    int               run_len;
    int               j;
    logic [TS_W-1:0]  ts;
    logic [IDX_W-1:0] idx;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < item_goal) begin
      if ($urandom_range(7) == 0) ts = TS_W'($urandom);
      else                        ts = TS_W'($urandom_range(TS_RANGE_TOP));
      if ($urandom_range(9) < 7) begin
        run_len = $urandom_range(48, 1);
        idx     = IDX_W'($urandom_range(NUM_FREQS - 1));
        for (j = 0; j < run_len; j++) begin
          send_item(ts, IDX_W'((int'(idx) + j) % NUM_FREQS));
        end
        sent += run_len;
      end else begin
        send_item(ts, IDX_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    int drain_wait;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_zero_index();
    test_index_saturation();
    test_wrapped_timestep();

    // Idling phases: none, heavy, light, then none again
    test_random_traffic(0, 460);
    test_random_traffic(64, 460);
    test_random_traffic(8, 460);
    test_random_traffic(0, 450);
    start_i <= 1'b0;

    // Drain the pipeline, then give it its latency again for strays
    drain_wait = 0;
    while (pending_pairs.size() != 0 && drain_wait < 2000) begin
      @(posedge clk_i);
      drain_wait++;
    end
    if (pending_pairs.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected results never arrived", $time, pending_pairs.size());
    end
    repeat (30) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run
  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
